// File: src/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants for the triangle tangent block
// Widths of the vertex and result fields and the control state encoding.
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int PosW  = 24;
	localparam int UvW   = 16;
	localparam int OutW  = 32;
	localparam int FracSh = 12;

	// edge: PosW+1, delta: UvW+1, det: 2*(UvW+1)+1, numerator: PosW+UvW+3
	localparam int EdgeW = PosW + 1;
	localparam int DltW  = UvW + 1;
	localparam int DetW  = 2 * DltW + 1;
	localparam int NumW  = EdgeW + DltW + 1;
	// dividend is |num| << FracSh; quotient needs NumW+FracSh bits before clamp
	localparam int DvdW  = NumW + FracSh;
	localparam int CntW  = $clog2(DvdW + 1);

	localparam int InDataW  = ((3 * PosW + 2 * UvW + 7) / 8) * 8;
	localparam int OutDataW = ((6 * OutW + 1 + 7) / 8) * 8;

	typedef enum logic [1:0] {
		PH_V0 = 2'd0,
		PH_V1 = 2'd1,
		PH_V2 = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_NEXT,
		ST_OUT
	} state_t;

	// handshake between the sequencer and the serial divider
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

// File: src/ttb_div.sv
// ----------------------------------------------------------------------------
// ttb_div: bit-serial restoring divider
// One quotient bit per cycle; signed Q20.12 result with saturation.
// ----------------------------------------------------------------------------
module ttb_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ttb_pkg::NumW-1:0]   num,
	input  logic signed [ttb_pkg::DetW-1:0]   den,
	output logic                              busy,
	output logic                              done,
	output logic [ttb_pkg::OutW-1:0]          quo
);

	localparam int DvdW = ttb_pkg::DvdW;
	localparam int DetW = ttb_pkg::DetW;
	localparam int OutW = ttb_pkg::OutW;

	logic [DvdW-1:0]        dvd_q;   // shifts out dividend, shifts in quotient
	logic [DetW:0]          rem_q;
	logic [DetW-1:0]        dmag_q;
	logic                   neg_q;
	logic [ttb_pkg::CntW-1:0] cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [DetW:0]          trial;
	logic [DetW+1:0]        diff;
	logic [ttb_pkg::NumW-1:0] nmag;
	logic [DetW-1:0]        dmag;
	logic                   ovf;
	logic [OutW:0]          mag;

	assign nmag = num[ttb_pkg::NumW-1] ? ttb_pkg::NumW'(-num) : ttb_pkg::NumW'(num);
	assign dmag = den[DetW-1] ? DetW'(-den) : DetW'(den);
	assign trial = {rem_q[DetW-1:0], dvd_q[DvdW-1]};
	assign diff  = {1'b0, trial} - {2'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ttb_pkg::CntW'(DvdW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ttb_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {nmag, {ttb_pkg::FracSh{1'b0}}};
			rem_q  <= '0;
			dmag_q <= dmag;
			neg_q  <= num[ttb_pkg::NumW-1] ^ den[DetW-1];
		end else if (busy_q) begin
			if (!diff[DetW+1]) begin
				rem_q <= diff[DetW:0];
				dvd_q <= {dvd_q[DvdW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
			end
		end
	end

	// quotient bits above bit 30 mean the magnitude is past the range
	assign ovf = |dvd_q[DvdW-1:OutW-1];
	assign mag = ovf ? {2'b01, {(OutW-1){1'b0}}} : {2'b00, dvd_q[OutW-2:0]};

	always_comb begin
		if (neg_q)
			quo = OutW'(-mag);
		else if (ovf)
			quo = {1'b0, {(OutW-1){1'b1}}};
		else
			quo = mag[OutW-1:0];
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// File: src/ttb_seq.sv
// ----------------------------------------------------------------------------
// ttb_seq: triangle sequencer
// Holds vertices, forms numerators one at a time and feeds the divider.
// ----------------------------------------------------------------------------
module ttb_seq (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_fire,
	input  logic [ttb_pkg::InDataW-1:0]          in_data,
	output logic                                 in_rdy,
	output logic                                 res_valid,
	input  logic                                 res_take,
	output logic [ttb_pkg::OutDataW-1:0]         res_data,
	output ttb_pkg::div_ctl_t                    dctl,
	output logic signed [ttb_pkg::NumW-1:0]      dnum,
	output logic signed [ttb_pkg::DetW-1:0]      dden,
	input  logic [ttb_pkg::OutW-1:0]             dquo,
	input  logic                                 dbusy,
	input  logic                                 ddone,
	output ttb_pkg::phase_t                      phase
);

	localparam int PosW = ttb_pkg::PosW;
	localparam int UvW  = ttb_pkg::UvW;
	localparam int OutW = ttb_pkg::OutW;

	ttb_pkg::phase_t  phase_q;
	ttb_pkg::state_t  state_q, state_d;

	logic signed [PosW-1:0] p0_q [3];
	logic signed [PosW-1:0] p1_q [3];
	logic signed [PosW-1:0] p2_q [3];
	logic signed [UvW-1:0]  t0_q [2];
	logic signed [UvW-1:0]  t1_q [2];
	logic signed [UvW-1:0]  t2_q [2];

	logic signed [ttb_pkg::DltW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [ttb_pkg::DetW-1:0] det_q;
	logic signed [ttb_pkg::NumW-1:0] num_q;
	logic [2:0]                      idx_q;   // result component 0..5
	logic [OutW-1:0]                 res_q [6];
	logic                            degen_q;
	logic                            start_q;

	logic signed [PosW-1:0] in_p [3];
	logic signed [UvW-1:0]  in_t [2];
	logic [1:0]             k;
	logic signed [ttb_pkg::EdgeW-1:0] e1, e2;
	logic signed [ttb_pkg::NumW-1:0]  pa, pb;

	always_comb begin
		for (int i = 0; i < 3; i++)
			in_p[i] = in_data[i*PosW +: PosW];
		for (int i = 0; i < 2; i++)
			in_t[i] = in_data[3*PosW + i*UvW +: UvW];
	end

	// one component per pass: 0..2 tangent, 3..5 bitangent
	assign k  = (idx_q >= 3'd3) ? 2'(idx_q - 3'd3) : idx_q[1:0];
	assign e1 = ttb_pkg::EdgeW'(p1_q[k]) - ttb_pkg::EdgeW'(p0_q[k]);
	assign e2 = ttb_pkg::EdgeW'(p2_q[k]) - ttb_pkg::EdgeW'(p0_q[k]);

	always_comb begin
		if (idx_q < 3'd3) begin
			pa = ttb_pkg::NumW'(dv2_q) * ttb_pkg::NumW'(e1);
			pb = ttb_pkg::NumW'(dv1_q) * ttb_pkg::NumW'(e2);
		end else begin
			pa = ttb_pkg::NumW'(du1_q) * ttb_pkg::NumW'(e2);
			pb = ttb_pkg::NumW'(du2_q) * ttb_pkg::NumW'(e1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttb_pkg::ST_IDLE: if (in_fire && phase_q == ttb_pkg::PH_V2) state_d = ttb_pkg::ST_PREP;
			ttb_pkg::ST_PREP: state_d = ttb_pkg::ST_NEXT;
			ttb_pkg::ST_NEXT: state_d = (det_q == '0) ? ttb_pkg::ST_OUT : ttb_pkg::ST_DIV;
			ttb_pkg::ST_DIV:  if (ddone) state_d = (idx_q == 3'd5) ? ttb_pkg::ST_OUT : ttb_pkg::ST_NEXT;
			ttb_pkg::ST_OUT:  if (res_take) state_d = ttb_pkg::ST_IDLE;
			default:          state_d = ttb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_rdy    = (state_q == ttb_pkg::ST_IDLE);
		res_valid = (state_q == ttb_pkg::ST_OUT);
		dctl.start = start_q;
		dctl.busy  = dbusy;
		dctl.done  = ddone;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttb_pkg::ST_IDLE;
			phase_q <= ttb_pkg::PH_V0;
			start_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			start_q <= 1'b0;
			if (in_fire) begin
				unique case (phase_q)
					ttb_pkg::PH_V0: phase_q <= ttb_pkg::PH_V1;
					ttb_pkg::PH_V1: phase_q <= ttb_pkg::PH_V2;
					default:        phase_q <= ttb_pkg::PH_V0;
				endcase
			end
			if (state_q == ttb_pkg::ST_PREP)
				idx_q <= '0;
			if (state_q == ttb_pkg::ST_NEXT && det_q != '0)
				start_q <= 1'b1;
			if (state_q == ttb_pkg::ST_DIV && ddone)
				idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			unique case (phase_q)
				ttb_pkg::PH_V1: begin
					p1_q <= in_p;
					t1_q <= in_t;
				end
				ttb_pkg::PH_V2: begin
					p2_q <= in_p;
					t2_q <= in_t;
				end
				default: begin
					p0_q <= in_p;
					t0_q <= in_t;
				end
			endcase
		end
		if (state_q == ttb_pkg::ST_PREP) begin
			du1_q <= ttb_pkg::DltW'(t1_q[0]) - ttb_pkg::DltW'(t0_q[0]);
			dv1_q <= ttb_pkg::DltW'(t1_q[1]) - ttb_pkg::DltW'(t0_q[1]);
			du2_q <= ttb_pkg::DltW'(t2_q[0]) - ttb_pkg::DltW'(t0_q[0]);
			dv2_q <= ttb_pkg::DltW'(t2_q[1]) - ttb_pkg::DltW'(t0_q[1]);
			det_q <= ttb_pkg::DetW'((ttb_pkg::DltW'(t1_q[0]) - ttb_pkg::DltW'(t0_q[0])))
				* ttb_pkg::DetW'((ttb_pkg::DltW'(t2_q[1]) - ttb_pkg::DltW'(t0_q[1])))
				- ttb_pkg::DetW'((ttb_pkg::DltW'(t2_q[0]) - ttb_pkg::DltW'(t0_q[0])))
				* ttb_pkg::DetW'((ttb_pkg::DltW'(t1_q[1]) - ttb_pkg::DltW'(t0_q[1])));
		end
		if (state_q == ttb_pkg::ST_NEXT) begin
			num_q   <= pa - pb;
			degen_q <= (det_q == '0);
			if (det_q == '0)
				for (int i = 0; i < 6; i++)
					res_q[i] <= '0;
		end
		if (state_q == ttb_pkg::ST_DIV && ddone)
			res_q[idx_q] <= dquo;
	end

	assign dnum = num_q;
	assign dden = det_q;
	assign phase = phase_q;

	always_comb begin
		res_data = '0;
		for (int i = 0; i < 6; i++)
			res_data[i*OutW +: OutW] = res_q[i];
		res_data[6*OutW] = degen_q;
	end

endmodule

// File: src/triangle_tangent_bitangent.sv
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent: per-triangle tangent and bitangent
// Three vertex beats in, one tangent/bitangent beat out per triangle.
// ----------------------------------------------------------------------------
// channel  dir  width  content
// s_axis   in   104    pos_x, pos_y, pos_z, tex_u, tex_v
// m_axis   out  200    tangent_xyz, bitangent_xyz, degenerate
//
// Each vertex is taken in one s_axis beat. After the third vertex a setup
// state forms the UV deltas and det, then six passes follow; each pass
// forms the numerator, loads the serial divider, takes 55 quotient bits at
// one per cycle and stores the result. A zero determinant skips the divider.
// s_axis_tready is low from the third vertex until the result beat is taken.
// Reset clears phase and state.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v
	input  logic [ttb_pkg::InDataW-1:0]      s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tangent_x, _y, _z, bitangent_x, _y, _z, degenerate
	output logic [ttb_pkg::OutDataW-1:0]     m_axis_tdata
);

	ttb_pkg::div_ctl_t                dctl;
	ttb_pkg::phase_t                  phase;
	logic signed [ttb_pkg::NumW-1:0]  dnum;
	logic signed [ttb_pkg::DetW-1:0]  dden;
	logic [ttb_pkg::OutW-1:0]         dquo;
	logic                             dbusy, ddone;
	logic                             in_fire;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	ttb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_data   (s_axis_tdata),
		.in_rdy    (s_axis_tready),
		.res_valid (m_axis_tvalid),
		.res_take  (m_axis_tready),
		.res_data  (m_axis_tdata),
		.dctl      (dctl),
		.dnum      (dnum),
		.dden      (dden),
		.dquo      (dquo),
		.dbusy     (dbusy),
		.ddone     (ddone),
		.phase     (phase)
	);

	ttb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dctl.start),
		.num    (dnum),
		.den    (dden),
		.busy   (dbusy),
		.done   (ddone),
		.quo    (dquo)
	);

`ifndef NO_ASSERTIONS
	a_no_in_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.busy |-> !s_axis_tready) else $error("input taken during divide");
	a_no_out_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.busy |-> !m_axis_tvalid) else $error("result shown during divide");
	a_phase_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase == ttb_pkg::PH_V2) |=> phase == ttb_pkg::PH_V0)
		else $error("phase did not wrap");
`endif

endmodule
